### rtl/ddet_pkg.sv
// ----------------------------------------------------------------------------
// ddet_pkg
// Shared widths, codes and controller types of the deadlock detector.
// ----------------------------------------------------------------------------
package ddet_pkg;

  // Default sizes of the process and resource stores.
  localparam int MAX_PROCESSES_DEF = 16;
  localparam int MAX_RESOURCES_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 8;

  // Fixed widths of the item, result and configuration fields.
  localparam int MODE_W      = 3;
  localparam int INDEX_W     = 4;
  localparam int AMOUNT_W    = 8;
  localparam int SLOT_W      = 4;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_SET_AVAILABLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_ALLOCATION = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_REQUEST    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET_ALIVE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DETECT         = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESOURCE_COUNT = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_SETTLE,
    ST_DECIDE,
    ST_SELECT,
    ST_EMIT
  } state_t;

  // Kind of pass that walks the resources of one row.
  typedef enum logic [1:0] {
    PH_COPY,
    PH_HOLD,
    PH_FIT,
    PH_UPDATE
  } phase_t;

endpackage

### rtl/deadlock_detector_unit.sv
// ----------------------------------------------------------------------------
// deadlock_detector_unit
// Resource deadlock detector. After reset the block clears its matrix
// memories, one entry a cycle, and stalls items meanwhile and while a
// detection runs. Load items (available count, allocation, request, alive
// flag) are written when taken. A detect item copies the available counts
// into the work vector, marks the alive processes that hold nothing, then
// runs the fit loop: it looks at the live unmarked processes in turn, checks
// their requests against the work vector and, on a fit, adds the allocation
// to the work vector, marks the process and restarts from the first one.
// With no processes or no resources the passes are skipped. Then one result
// per process slot (a single one with no processes) is offered, one per cycle
// while the receiver takes them. The allocation and request memories give
// one entry per read port each cycle, so every pass walks resources one at a
// time. The process and resource counts in use are limited to the maxima.
// ----------------------------------------------------------------------------
module deadlock_detector_unit import ddet_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [MODE_W-1:0]      mode,
  input  logic [INDEX_W-1:0]     process,
  input  logic [INDEX_W-1:0]     resource,
  input  logic [AMOUNT_W-1:0]    amount,
  // Result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [SLOT_W-1:0]      slot,
  output logic                   deadlocked,
  output logic                   last
);

  localparam int PW       = $clog2(MAX_PROCESSES);
  localparam int CPW      = $clog2(MAX_PROCESSES + 1);
  localparam int RW       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NRW      = $clog2(MAX_RESOURCES + 1);
  localparam int Depth    = (MAX_PROCESSES + 1) * MAX_RESOURCES;
  localparam int AW       = $clog2(Depth);
  localparam int CountMax = (1 << COUNT_WIDTH) - 1;

  // The row past the last process holds the work vector in the allocation
  // memory and the available counts in the request memory.
  localparam logic [CPW-1:0] ROW_EXTRA = CPW'(MAX_PROCESSES);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(Depth - 1);

  typedef struct packed {
    logic           valid;
    logic           last_r;
    logic [CPW-1:0] p;
    logic [RW-1:0]  r;
  } beat_t;

  state_t state, state_next;
  phase_t phase;

  logic [CFG_DATA_W-1:0]    process_count;
  logic [CFG_DATA_W-1:0]    resource_count;
  logic [MAX_PROCESSES-1:0] alive;
  logic [MAX_PROCESSES-1:0] finish;
  logic [MAX_PROCESSES-1:0] used_mask;
  logic [CPW-1:0]           p_cnt;
  logic [RW-1:0]            r_cnt;
  logic [AW-1:0]            clr_addr;
  beat_t                    beat;
  logic                     holds_acc;
  logic                     fail_acc;

  logic [CPW-1:0]         np;
  logic [NRW-1:0]         nr;
  logic [PW-1:0]          pi;
  logic [PW-1:0]          beat_pi;
  logic [PW-1:0]          in_pi;
  logic [CPW-1:0]         in_p;
  logic [RW-1:0]          in_r;
  logic                   p_ok;
  logic                   r_ok;
  logic [COUNT_WIDTH-1:0] in_count;
  logic                   item_fire;
  logic                   out_free;
  logic                   r_last;
  logic                   p_last;
  logic                   emit_last;
  logic                   holds_now;
  logic                   fail_now;
  logic [COUNT_WIDTH:0]   work_sum;
  logic [COUNT_WIDTH-1:0] work_sat;

  logic                   a_we;
  logic [AW-1:0]          a_waddr;
  logic [COUNT_WIDTH-1:0] a_wdata;
  logic [AW-1:0]          a_raddr0;
  logic [AW-1:0]          a_raddr1;
  logic [COUNT_WIDTH-1:0] a_rd0;
  logic [COUNT_WIDTH-1:0] a_rd1;
  logic                   b_we;
  logic [AW-1:0]          b_waddr;
  logic [COUNT_WIDTH-1:0] b_wdata;
  logic [AW-1:0]          b_raddr;
  logic [COUNT_WIDTH-1:0] b_rd;
  logic [COUNT_WIDTH-1:0] b_rd1;

  function automatic logic [AW-1:0] row_addr(input logic [CPW-1:0] p,
                                             input logic [RW-1:0] r);
    return AW'(p) * AW'(MAX_RESOURCES) + AW'(r);
  endfunction

  // Allocation rows plus the work vector.
  ddet_ram #(
    .DEPTH (Depth),
    .WIDTH (COUNT_WIDTH)
  ) u_alloc_mem (
    .clk       (clk),
    .wr_en     (a_we),
    .wr_addr   (a_waddr),
    .wr_data   (a_wdata),
    .rd_addr_a (a_raddr0),
    .rd_data_a (a_rd0),
    .rd_addr_b (a_raddr1),
    .rd_data_b (a_rd1)
  );

  // Request rows plus the available counts; the second port reads the
  // available count of the same resource as the work vector read.
  ddet_ram #(
    .DEPTH (Depth),
    .WIDTH (COUNT_WIDTH)
  ) u_req_mem (
    .clk       (clk),
    .wr_en     (b_we),
    .wr_addr   (b_waddr),
    .wr_data   (b_wdata),
    .rd_addr_a (b_raddr),
    .rd_data_a (b_rd),
    .rd_addr_b (a_raddr1),
    .rd_data_b (b_rd1)
  );

  // Counts in use, limited to the store sizes.
  assign np = (32'(process_count) > MAX_PROCESSES) ? CPW'(MAX_PROCESSES) : CPW'(process_count);
  assign nr = (32'(resource_count) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES) : NRW'(resource_count);

  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      used_mask[i] = (i < int'(np));
    end
  end

  // Item decode.
  assign item_stall = (state != ST_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign p_ok       = (32'(process) < MAX_PROCESSES);
  assign r_ok       = (32'(resource) < MAX_RESOURCES);
  assign in_p       = CPW'(process);
  assign in_pi      = PW'(process);
  assign in_r       = RW'(resource);
  assign in_count   = (32'(amount) > CountMax) ? COUNT_WIDTH'(CountMax) : COUNT_WIDTH'(amount);

  // Pass bookkeeping.
  assign pi        = p_cnt[PW-1:0];
  assign beat_pi   = beat.p[PW-1:0];
  assign r_last    = (NRW'(r_cnt) == nr - NRW'(1));
  assign p_last    = (p_cnt == np - CPW'(1));
  assign out_free  = !result_valid || !result_stall;
  assign emit_last = (np == '0) || p_last;

  // Beat evaluation: a fresh row starts its accumulators at resource zero.
  assign holds_now = ((beat.r != '0) && holds_acc) || (a_rd0 != '0);
  assign fail_now  = ((beat.r != '0) && fail_acc) || (b_rd > a_rd1);
  assign work_sum  = {1'b0, a_rd1} + {1'b0, a_rd0};
  assign work_sat  = work_sum[COUNT_WIDTH] ? '1 : work_sum[COUNT_WIDTH-1:0];

  // Read addresses run freely; only the beats that follow an issue are used.
  assign a_raddr0 = row_addr(p_cnt, r_cnt);
  assign a_raddr1 = row_addr(ROW_EXTRA, r_cnt);
  assign b_raddr  = row_addr(p_cnt, r_cnt);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory write controls.
  always_comb begin
    state_next = state;
    a_we       = 1'b0;
    a_waddr    = row_addr(ROW_EXTRA, beat.r);
    a_wdata    = work_sat;
    b_we       = 1'b0;
    b_waddr    = row_addr(ROW_EXTRA, in_r);
    b_wdata    = in_count;

    unique case (state)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_addr;
        a_wdata = '0;
        b_we    = 1'b1;
        b_waddr = clr_addr;
        b_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_fire) begin
          unique case (mode)
            MODE_SET_AVAILABLE: begin
              b_we = r_ok;
            end
            MODE_SET_ALLOCATION: begin
              a_we    = p_ok && r_ok;
              a_waddr = row_addr(in_p, in_r);
              a_wdata = in_count;
            end
            MODE_SET_REQUEST: begin
              b_we    = p_ok && r_ok;
              b_waddr = row_addr(in_p, in_r);
            end
            MODE_DETECT: begin
              state_next = ((np == '0) || (nr == '0)) ? ST_EMIT : ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (r_last && !(phase == PH_HOLD && !p_last)) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (phase)
          PH_COPY:   state_next = ST_ISSUE;
          PH_HOLD:   state_next = ST_SELECT;
          PH_FIT:    state_next = fail_acc ? ST_SELECT : ST_ISSUE;
          PH_UPDATE: state_next = ST_SELECT;
        endcase
      end
      ST_SELECT: begin
        priority if (p_cnt == np) begin
          state_next = ST_EMIT;
        end else if (alive[pi] && !finish[pi]) begin
          state_next = ST_ISSUE;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Work vector writes follow their reads in the next cycle, when the read data arrives.
    if (beat.valid) begin
      if (phase == PH_COPY) begin
        a_we    = 1'b1;
        a_wdata = b_rd1;
      end else if (phase == PH_UPDATE) begin
        a_we = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= '0;
      resource_count <= '0;
      alive          <= '0;
      finish         <= '0;
      phase          <= PH_COPY;
      p_cnt          <= '0;
      r_cnt          <= '0;
      clr_addr       <= '0;
      beat           <= '0;
      holds_acc      <= 1'b0;
      fail_acc       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PROCESS_COUNT:  process_count  <= cfg_data;
          REG_RESOURCE_COUNT: resource_count <= cfg_data;
        endcase
      end

      beat <= '0;

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        ST_IDLE: begin
          if (item_fire && mode == MODE_SET_ALIVE && p_ok) begin
            alive[in_pi] <= amount[0];
          end
          if (item_fire && mode == MODE_DETECT) begin
            p_cnt  <= '0;
            r_cnt  <= '0;
            phase  <= PH_COPY;
            // With no resources every live process holds nothing.
            finish <= (nr == '0) ? (alive & used_mask) : '0;
          end
        end
        ST_ISSUE: begin
          beat.valid  <= 1'b1;
          beat.last_r <= r_last;
          beat.p      <= p_cnt;
          beat.r      <= r_cnt;
          if (r_last) begin
            r_cnt <= '0;
            if (phase == PH_HOLD && !p_last) begin
              p_cnt <= p_cnt + CPW'(1);
            end
          end else begin
            r_cnt <= r_cnt + RW'(1);
          end
        end
        ST_SETTLE: ;
        ST_DECIDE: begin
          unique case (phase)
            PH_COPY: begin
              phase <= PH_HOLD;
              p_cnt <= '0;
            end
            PH_HOLD: begin
              p_cnt <= '0;
            end
            PH_FIT: begin
              if (fail_acc) begin
                p_cnt <= p_cnt + CPW'(1);
              end else begin
                phase <= PH_UPDATE;
              end
            end
            PH_UPDATE: begin
              // Progress: mark the process and rescan from the first slot.
              finish[pi] <= 1'b1;
              p_cnt      <= '0;
            end
          endcase
        end
        ST_SELECT: begin
          priority if (p_cnt == np) begin
            p_cnt <= '0;
          end else if (!alive[pi] || finish[pi]) begin
            p_cnt <= p_cnt + CPW'(1);
          end else begin
            phase <= PH_FIT;
          end
        end
        ST_EMIT: begin
          if (out_free && !emit_last) begin
            p_cnt <= p_cnt + CPW'(1);
          end
        end
        default: ;
      endcase

      // Absorb the read data of the previous cycle.
      if (beat.valid) begin
        unique case (phase)
          PH_HOLD: begin
            holds_acc <= holds_now;
            if (beat.last_r) begin
              finish[beat_pi] <= alive[beat_pi] && !holds_now;
            end
          end
          PH_FIT: begin
            fail_acc <= fail_now;
          end
          default: ;
        endcase
      end

      // Output register: a new result loads once the old one is transferred.
      if (out_free) begin
        result_valid <= (state == ST_EMIT);
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      slot       <= SLOT_W'(p_cnt);
      deadlocked <= (np != '0) && alive[pi] && !finish[pi];
      last       <= emit_last;
    end
  end

  // A fit check is only started for a live process that is still unmarked.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE && phase == PH_FIT) |-> (alive[pi] && !finish[pi]))
    else $error("fit check started on a dead or marked process");

  // Read data is only taken in the cycle after a read was issued.
  assert property (@(posedge clk) disable iff (rst)
    beat.valid |-> ($past(state) == ST_ISSUE))
    else $error("data beat without a preceding read issue");

  // The selection pointer never runs past the slots in use.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SELECT) |-> (p_cnt <= np))
    else $error("process pointer beyond the slots in use");

  // A new result only appears while a detection run is emitting.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> ($past(state) == ST_EMIT))
    else $error("result offered outside the emit phase");

endmodule

### rtl/ddet_ram.sv
// ----------------------------------------------------------------------------
// ddet_ram
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ddet_ram import ddet_pkg::*; #(
  parameter int DEPTH = (MAX_PROCESSES_DEF + 1) * MAX_RESOURCES_DEF,
  parameter int WIDTH = COUNT_WIDTH_DEF,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AddrW-1:0] rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a read of the same entry returns the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### tb/tb_deadlock_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadlock_detector_unit
// Self-checking bench for the deadlock detector. Load and detect items are
// fed from a backlog by a clocked driver. A clocked monitor compares every
// result with the verdicts that the bench's own copy of the matrices and of
// the detection algorithm predicts. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_deadlock_detector_unit import ddet_pkg::*; ();

  localparam int NP           = MAX_PROCESSES_DEF;
  localparam int NR           = MAX_RESOURCES_DEF;
  localparam int CW           = COUNT_WIDTH_DEF;
  localparam int COUNT_TOP    = (1 << CW) - 1;
  localparam int RANDOM_ITEMS = 210;
  localparam int SETTLE       = 20;
  localparam int DRAIN        = 40;
  // Guard on the run length; a full 16 x 16 detection with stalled results
  // and the whole run stay far below it.
  localparam int LIMIT        = 2_000_000;

  // Modes that the block decodes as nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  proc_idx;
    logic [INDEX_W-1:0]  res_idx;
    logic [AMOUNT_W-1:0] amount;
  } load_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              deadlocked;
    logic              last;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [MODE_W-1:0]      item_mode = '0;
  logic [INDEX_W-1:0]     item_process = '0;
  logic [INDEX_W-1:0]     item_resource = '0;
  logic [AMOUNT_W-1:0]    item_amount = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [SLOT_W-1:0]      slot;
  logic                   deadlocked;
  logic                   last;

  // Bench copy of the detector state and registers.
  logic [CW-1:0]         avail_store [NR];
  logic [CW-1:0]         alloc_store [NP][NR];
  logic [CW-1:0]         want_store  [NP][NR];
  logic                  alive_store [NP];
  logic [CFG_DATA_W-1:0] proc_count_reg = '0;
  logic [CFG_DATA_W-1:0] res_count_reg = '0;

  load_item_t item_backlog[$];
  verdict_t   expected_verdicts[$];
  load_item_t cur_item;
  logic       drive_next;
  int         gap_left = 0;
  int         hold_left = 0;
  bit         quiet = 1'b0;
  int         error_count = 0;
  int         counted_items = 0;
  int         detect_runs = 0;
  int         results_checked = 0;
  int         cycle_count = 0;

  deadlock_detector_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (item_mode),
    .process      (item_process),
    .resource     (item_resource),
    .amount       (item_amount),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .slot         (slot),
    .deadlocked   (deadlocked),
    .last         (last)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               expected_verdicts.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void flag_mismatch(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Gap length for either channel: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Classic detection over the bench copy; queues one verdict per slot in use (one when none is in use).
  function automatic void predict_detection();
    int       np;
    int       nr;
    int       sum;
    bit       grew;
    bit       holds;
    bit       fits;
    bit       marked [NP];
    logic [CW-1:0] work [NR];
    verdict_t v;
    np = (proc_count_reg > NP) ? NP : int'(proc_count_reg);
    nr = (res_count_reg > NR) ? NR : int'(res_count_reg);
    for (int r = 0; r < NR; r++) work[r] = avail_store[r];
    for (int p = 0; p < NP; p++) marked[p] = 1'b0;
    // Alive processes that hold nothing finish at once.
    for (int p = 0; p < np; p++) begin
      if (alive_store[p]) begin
        holds = 1'b0;
        for (int r = 0; r < nr; r++) if (alloc_store[p][r] != 0) holds = 1'b1;
        if (!holds) marked[p] = 1'b1;
      end
    end
    // Mark the first process whose requests fit, release its holdings and rescan.
    do begin
      grew = 1'b0;
      for (int p = 0; p < np && !grew; p++) begin
        if (!alive_store[p] || marked[p]) continue;
        fits = 1'b1;
        for (int r = 0; r < nr; r++) if (want_store[p][r] > work[r]) fits = 1'b0;
        if (fits) begin
          marked[p] = 1'b1;
          for (int r = 0; r < nr; r++) begin
            sum = int'(work[r]) + int'(alloc_store[p][r]);
            work[r] = (sum > COUNT_TOP) ? CW'(COUNT_TOP) : CW'(sum);
          end
          grew = 1'b1;
        end
      end
    end while (grew);
    if (np == 0) begin
      v.slot = '0;
      v.deadlocked = 1'b0;
      v.last = 1'b1;
      expected_verdicts.push_back(v);
    end else begin
      for (int p = 0; p < np; p++) begin
        v.slot = SLOT_W'(p);
        v.deadlocked = alive_store[p] && !marked[p];
        v.last = (p == np - 1);
        expected_verdicts.push_back(v);
      end
    end
  endfunction

  // Applies one accepted item to the bench copy. Counts are as wide as the
  // stores, so no clamping is needed at the default sizes.
  function automatic void apply_item(load_item_t it);
    case (it.mode)
      MODE_SET_AVAILABLE:  avail_store[it.res_idx] = it.amount;
      MODE_SET_ALLOCATION: alloc_store[it.proc_idx][it.res_idx] = it.amount;
      MODE_SET_REQUEST:    want_store[it.proc_idx][it.res_idx] = it.amount;
      MODE_SET_ALIVE:      alive_store[it.proc_idx] = it.amount[0];
      MODE_DETECT: begin
        detect_runs++;
        predict_detection();
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [MODE_W-1:0] m, int p, int r, int amt);
    load_item_t it;
    it.mode = m;
    it.proc_idx = INDEX_W'(p);
    it.res_idx = INDEX_W'(r);
    it.amount = AMOUNT_W'(amt);
    item_backlog.push_back(it);
    if (m <= MODE_DETECT) counted_items++;
  endfunction

  // Item driver: holds the payload until the transfer, then waits out a gap.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      drive_next = item_valid;
      if (item_valid && !item_stall) begin
        apply_item(cur_item);
        drive_next = 1'b0;
      end
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          item_mode <= cur_item.mode;
          item_process <= cur_item.proc_idx;
          item_resource <= cur_item.res_idx;
          item_amount <= cur_item.amount;
          drive_next = 1'b1;
          gap_left = pick_gap();
        end
      end
      item_valid <= drive_next;
    end
  end

  // Result monitor and random receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result slot %0d deadlocked %0d last %0d",
                                  slot, deadlocked, last));
        end else begin
          results_checked++;
          if (expected_verdicts[0].slot !== slot ||
              expected_verdicts[0].deadlocked !== deadlocked ||
              expected_verdicts[0].last !== last)
            flag_mismatch($sformatf("slot/deadlocked/last expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                    expected_verdicts[0].slot, expected_verdicts[0].deadlocked,
                                    expected_verdicts[0].last, slot, deadlocked, last));
          void'(expected_verdicts.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        if ($urandom_range(0, 99) < 25) hold_left = pick_gap();
      end
    end
  end

  // Register write, mirrored into the bench copy of the count registers.
  task automatic write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_PROCESS_COUNT) proc_count_reg = val;
    else proc_count_reg = proc_count_reg;
    if (idx == REG_RESOURCE_COUNT) res_count_reg = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits for all items to be taken and all verdicts to arrive, then lets a
  // trailing load item finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (item_backlog.size() != 0 || item_valid || expected_verdicts.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 30) return CFG_DATA_W'(NP);
    if (roll < 38) return CFG_DATA_W'($urandom_range(NP + 1, 31));
    return CFG_DATA_W'($urandom_range(1, NP - 1));
  endfunction

  function automatic int pick_amount();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
    return $urandom_range(0, COUNT_TOP);
  endfunction

  // One load sequence over the slots in use, mostly small counts, a little
  // noise, closed by a detect.
  task automatic queue_scenario();
    int np_eff;
    int nr_eff;
    int p_hi;
    int r_hi;
    int unsigned roll;
    np_eff = (proc_count_reg > NP) ? NP : int'(proc_count_reg);
    nr_eff = (res_count_reg > NR) ? NR : int'(res_count_reg);
    p_hi = (np_eff == 0) ? NP - 1 : np_eff - 1;
    r_hi = (nr_eff == 0) ? NR - 1 : nr_eff - 1;
    repeat ($urandom_range(4, 14)) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        add_item(MODE_W'($urandom_range(0, 7)), $urandom_range(0, NP - 1),
                 $urandom_range(0, NR - 1), $urandom_range(0, COUNT_TOP));
      else if (roll < 25)
        add_item(MODE_SET_AVAILABLE, $urandom_range(0, NP - 1), $urandom_range(0, r_hi),
                 pick_amount());
      else if (roll < 50)
        add_item(MODE_SET_ALLOCATION, $urandom_range(0, p_hi), $urandom_range(0, r_hi),
                 pick_amount());
      else if (roll < 75)
        add_item(MODE_SET_REQUEST, $urandom_range(0, p_hi), $urandom_range(0, r_hi),
                 pick_amount());
      else
        add_item(MODE_SET_ALIVE, $urandom_range(0, p_hi), $urandom_range(0, NR - 1),
                 ($urandom_range(0, 127) << 1) | int'($urandom_range(0, 99) < 80));
    end
    add_item(MODE_DETECT, $urandom_range(0, NP - 1), $urandom_range(0, NR - 1),
             $urandom_range(0, COUNT_TOP));
  endtask

  // Stimulus and end of run.
  initial begin
    for (int r = 0; r < NR; r++) avail_store[r] = '0;
    for (int p = 0; p < NP; p++) begin
      alive_store[p] = 1'b0;
      for (int r = 0; r < NR; r++) begin
        alloc_store[p][r] = '0;
        want_store[p][r] = '0;
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // No processes in use: a single empty verdict.
    write_config(REG_PROCESS_COUNT, '0);
    write_config(REG_RESOURCE_COUNT, '0);
    add_item(MODE_DETECT, 0, 0, 0);
    wait_idle();

    // Two processes waiting on each other, one idle one; then one dies and
    // finally the request is satisfied.
    write_config(REG_PROCESS_COUNT, CFG_DATA_W'(3));
    write_config(REG_RESOURCE_COUNT, CFG_DATA_W'(2));
    add_item(MODE_SET_AVAILABLE, 0, 0, 0);
    add_item(MODE_SET_AVAILABLE, 0, 1, 0);
    add_item(MODE_SET_ALLOCATION, 0, 0, 1);
    add_item(MODE_SET_REQUEST, 0, 1, 1);
    add_item(MODE_SET_ALLOCATION, 1, 1, 1);
    add_item(MODE_SET_REQUEST, 1, 0, 1);
    add_item(MODE_SET_ALIVE, 0, 0, 1);
    add_item(MODE_SET_ALIVE, 1, 0, 1);
    add_item(MODE_SET_ALIVE, 2, 0, 1);
    add_item(MODE_DETECT, 0, 0, 0);
    add_item(MODE_SET_ALIVE, 1, 0, 'hFE);
    add_item(MODE_DETECT, 0, 0, 0);
    add_item(MODE_SET_AVAILABLE, 0, 1, 1);
    add_item(MODE_DETECT, 0, 0, 0);
    wait_idle();

    // Oversized registers, top indexes, full counts with saturating work,
    // and the unused modes.
    write_config(REG_PROCESS_COUNT, '1);
    write_config(REG_RESOURCE_COUNT, '1);
    add_item(MODE_SET_AVAILABLE, 15, 15, COUNT_TOP);
    add_item(MODE_SET_ALLOCATION, 15, 15, COUNT_TOP);
    add_item(MODE_SET_ALLOCATION, 14, 15, COUNT_TOP);
    add_item(MODE_SET_REQUEST, 14, 15, COUNT_TOP);
    add_item(MODE_SET_REQUEST, 15, 0, 1);
    add_item(MODE_SET_ALIVE, 15, 15, COUNT_TOP);
    add_item(MODE_SET_ALIVE, 14, 0, 1);
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
      add_item(MODE_W'(m), 15, 15, COUNT_TOP);
    add_item(MODE_DETECT, 15, 15, COUNT_TOP);
    wait_idle();

    // Random phases, each with its own register setting; every phase drains
    // completely before the next setting is written.
    while (counted_items < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      write_config(REG_PROCESS_COUNT, pick_count());
      write_config(REG_RESOURCE_COUNT, pick_count());
      repeat ($urandom_range(1, 3)) queue_scenario();
      wait_idle();
    end
    repeat (DRAIN) @(posedge clk);

    $display("Summary: %0d load and detect items sent, %0d detection runs, %0d results checked",
             counted_items, detect_runs, results_checked);
    $display("Summary: %0d errors over %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
